// File: rtl/wav_pcm_mono16_parser_unit_assert.svh
// Assertion macros shared by the parser unit.
`ifndef WAV_PCM_MONO16_PARSER_UNIT_ASSERT_SVH
`define WAV_PCM_MONO16_PARSER_UNIT_ASSERT_SVH

// The condition must never hold at a clock edge outside reset.
`define WPM_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("wpm assertion failed: forbidden condition seen");

// The consequent must hold in the same cycle as the antecedent.
`define WPM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wpm assertion failed: implication violated");

`endif

// File: rtl/wpm_pkg.sv
// Types and constants shared by the WAV parser modules.
package wpm_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  localparam logic [3:0] ERR_RIFF      = 4'd0;
  localparam logic [3:0] ERR_WAVE      = 4'd1;
  localparam logic [3:0] ERR_FMT_TAG   = 4'd2;
  localparam logic [3:0] ERR_FMT_SIZE  = 4'd3;
  localparam logic [3:0] ERR_FORMAT    = 4'd4;
  localparam logic [3:0] ERR_CHANNELS  = 4'd5;
  localparam logic [3:0] ERR_BITS      = 4'd6;
  localparam logic [3:0] ERR_DATA_TAG  = 4'd7;
  localparam logic [3:0] ERR_TRUNCATED = 4'd8;

  localparam logic [31:0] TagRiff    = 32'h52494646;
  localparam logic [31:0] TagWave    = 32'h57415645;
  localparam logic [31:0] TagFmt     = 32'h666d7420;
  localparam logic [31:0] TagData    = 32'h64617461;
  localparam logic [31:0] FmtSizePcm = 32'h00000010;
  localparam logic [15:0] FormatPcm  = 16'h0001;
  localparam logic [15:0] MonoChans  = 16'h0001;
  localparam logic [15:0] Bits16     = 16'h0010;
  localparam logic [5:0]  HeaderLast = 6'd43;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] sample;
    logic [3:0]         error_code;
    logic [31:0]        samp_rate;
    logic [31:0]        bytes_per_sec;
    logic [15:0]        frame_align;
    logic [31:0]        data_len;
    logic [31:0]        riff_size;
    logic [30:0]        sample_count;
  } result_t;

  typedef struct packed {
    logic        prim_valid;
    result_t     prim;
    logic        end_valid;
    logic [30:0] end_count;
  } cmd_t;

  typedef struct packed {
    logic cmd_pop;
    logic second;
  } back_stat_t;

endpackage

// File: rtl/wav_pcm_mono16_parser_unit.sv
// Mono 16-bit PCM WAV stream parser, top level.
//
// Input channel: one byte of a WAV file per word, with last_byte set on the
// final byte. A word is taken when push is high and full is low.
// Result channel: while empty is low, the oldest result word is on
// out_word_o; it is taken when pop is high.
// A result word is registered in the command queue when its byte is taken,
// and shown from there. The parser sustains one byte per cycle while full
// is low; at most two result words come from one byte, the final byte only.
// The parser front and the result back end are parted by a four-entry
// command queue, so full rises only after the receiver has stalled long
// enough to fill it; while it is full every byte waits, even one that
// gives no result.
// Reset clears the parser to the start of a file and empties the queue.
// After every final byte the parser returns to the start of a new file.
module wav_pcm_mono16_parser_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  wpm_pkg::in_t     in_word_i,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output wpm_pkg::result_t out_word_o
);
  import wpm_pkg::*;

`include "wav_pcm_mono16_parser_unit_assert.svh"

  logic       in_fire;
  logic       cmd_valid;
  cmd_t       cmd_front;
  cmd_t       cmd_head;
  logic       cmd_empty;
  logic       cmd_pop;
  back_stat_t back_stat;

  assign in_fire = push & ~full;

  wpm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_front)
  );

  wpm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd_front),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_head)
  );

  wpm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_word_o  (out_word_o),
    .empty_o     (empty),
    .pop_i       (pop),
    .stat_o      (back_stat)
  );

  `WPM_ASSERT_NEVER(a_pop_when_empty, back_stat.cmd_pop && cmd_empty)
  `WPM_ASSERT_IMPLY(a_second_is_end, back_stat.second && !empty, out_word_o.kind == KIND_END)
  `WPM_ASSERT_IMPLY(a_second_has_end, back_stat.second && !cmd_empty, cmd_head.end_valid)
  `WPM_ASSERT_NEVER(a_full_and_empty, full && cmd_empty)

endmodule

// File: rtl/wpm_queue.sv
// Small command queue between the parser front and the result back end.
module wpm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wpm_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output wpm_pkg::cmd_t data_o
);
  import wpm_pkg::*;

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/wpm_front.sv
// Parser front: assembles the header, checks it and classifies data bytes.
module wpm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  wpm_pkg::in_t  in_word_i,
  output logic          cmd_valid_o,
  output wpm_pkg::cmd_t cmd_o
);
  import wpm_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [32:0] pos_q, pos_d;
  logic [30:0] count_q, count_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] riff_q, riff_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] brate_q, brate_d;
  logic [15:0] align_q, align_d;
  logic [7:0]  low_q, low_d;

  logic        big_endian;
  logic [31:0] shift_new;
  logic [15:0] hi;
  logic [5:0]  p6;
  logic [32:0] limit;
  logic        err_valid;
  logic [3:0]  err_code;
  logic [7:0]  b;
  logic        last;

  assign b     = in_word_i.byte_value;
  assign last  = in_word_i.last_byte;
  assign p6    = pos_q[5:0];
  assign limit = {1'b0, riff_q} + 33'd8;

  assign big_endian = (pos_q < 33'd4) || (pos_q >= 33'd8 && pos_q < 33'd16) ||
                      (pos_q >= 33'd36 && pos_q < 33'd40);
  assign shift_new  = big_endian ? {shift_q[23:0], b} : {b, shift_q[31:8]};
  assign hi         = shift_new[31:16];

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    count_d   = count_q;
    shift_d   = shift_q;
    riff_d    = riff_q;
    rate_d    = rate_q;
    brate_d   = brate_q;
    align_d   = align_q;
    low_d     = low_q;
    err_valid = 1'b0;
    err_code  = ERR_RIFF;
    cmd_o     = '0;
    if (in_fire_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          shift_d = shift_new;
          case (p6)
            6'd3: if (shift_new != TagRiff) begin
              err_valid = 1'b1;
              err_code  = ERR_RIFF;
            end
            6'd7: riff_d = shift_new;
            6'd11: if (shift_new != TagWave) begin
              err_valid = 1'b1;
              err_code  = ERR_WAVE;
            end
            6'd15: if (shift_new != TagFmt) begin
              err_valid = 1'b1;
              err_code  = ERR_FMT_TAG;
            end
            6'd19: if (shift_new != FmtSizePcm) begin
              err_valid = 1'b1;
              err_code  = ERR_FMT_SIZE;
            end
            6'd21: if (hi != FormatPcm) begin
              err_valid = 1'b1;
              err_code  = ERR_FORMAT;
            end
            6'd23: if (hi != MonoChans) begin
              err_valid = 1'b1;
              err_code  = ERR_CHANNELS;
            end
            6'd27: rate_d = shift_new;
            6'd31: brate_d = shift_new;
            6'd33: align_d = hi;
            6'd35: if (hi != Bits16) begin
              err_valid = 1'b1;
              err_code  = ERR_BITS;
            end
            6'd39: if (shift_new != TagData) begin
              err_valid = 1'b1;
              err_code  = ERR_DATA_TAG;
            end
            HeaderLast: begin
              cmd_o.prim_valid         = 1'b1;
              cmd_o.prim.kind          = KIND_HEADER;
              cmd_o.prim.samp_rate     = rate_q;
              cmd_o.prim.bytes_per_sec = brate_q;
              cmd_o.prim.frame_align   = align_q;
              cmd_o.prim.data_len      = shift_new;
              cmd_o.prim.riff_size     = riff_q;
              phase_d                  = PH_DATA;
            end
            default: ;
          endcase
          if (!err_valid && last && pos_q < {27'd0, HeaderLast}) begin
            err_valid = 1'b1;
            err_code  = ERR_TRUNCATED;
          end
          if (err_valid) begin
            cmd_o.prim_valid      = 1'b1;
            cmd_o.prim.kind       = KIND_ERROR;
            cmd_o.prim.error_code = err_code;
            phase_d               = PH_SKIP;
          end
        end
        PH_DATA: begin
          if (!pos_q[0]) begin
            low_d = b;
          end else if (pos_q < limit) begin
            cmd_o.prim_valid  = 1'b1;
            cmd_o.prim.kind   = KIND_SAMPLE;
            cmd_o.prim.sample = {b, low_q};
            if (count_q != '1) begin
              count_d = count_q + 1'b1;
            end
          end
        end
        PH_SKIP: ;
        default: ;
      endcase
      if (last && phase_d == PH_DATA) begin
        cmd_o.end_valid = 1'b1;
        cmd_o.end_count = count_d;
      end
      if (pos_q != '1) begin
        pos_d = pos_q + 1'b1;
      end
      if (last) begin
        phase_d = PH_HEADER;
        pos_d   = '0;
        count_d = '0;
      end
    end
  end

  assign cmd_valid_o = in_fire_i & (cmd_o.prim_valid | cmd_o.end_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    riff_q  <= riff_d;
    rate_q  <= rate_d;
    brate_q <= brate_d;
    align_q <= align_d;
    low_q   <= low_d;
  end

endmodule

// File: rtl/wpm_back.sv
// Result back end: expands queued commands into one or two result words.
module wpm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wpm_pkg::cmd_t       cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  output wpm_pkg::result_t    out_word_o,
  output logic                empty_o,
  input  logic                pop_i,
  output wpm_pkg::back_stat_t stat_o
);
  import wpm_pkg::*;

  logic second_q, second_d;
  logic show_end;
  logic fire;

  assign show_end = second_q | ~cmd_i.prim_valid;
  assign empty_o  = cmd_empty_i;
  assign fire     = pop_i & ~cmd_empty_i;

  always_comb begin
    out_word_o = cmd_i.prim;
    if (show_end) begin
      out_word_o              = '0;
      out_word_o.kind         = KIND_END;
      out_word_o.sample_count = cmd_i.end_count;
    end
  end

  assign cmd_pop_o = fire & (show_end | ~cmd_i.end_valid);

  always_comb begin
    second_d = second_q;
    if (fire) begin
      second_d = ~cmd_pop_o;
    end
  end

  assign stat_o.cmd_pop = cmd_pop_o;
  assign stat_o.second  = second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else begin
      second_q <= second_d;
    end
  end

endmodule

// File: bench/tb.sv
// Self-checking testbench for the mono 16-bit PCM WAV parser with a byte-level predictor.
`timescale 1ns / 100ps

module tb;
  import wpm_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_SKIP
  } parse_phase_e;

  logic    clk_i;
  logic    rst_ni;
  logic    push;
  in_t     in_word_i;
  logic    full;
  logic    empty;
  logic    pop;
  result_t out_word_o;

  wav_pcm_mono16_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_word_i  (in_word_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

  // Predictor state for the file being parsed.
  parse_phase_e parse_phase;
  logic [32:0]  byte_pos;
  logic [31:0]  field_bits;
  logic [31:0]  riff_size_q;
  logic [31:0]  rate_q;
  logic [31:0]  brate_q;
  logic [15:0]  align_q;
  logic [31:0]  data_len_q;
  logic [7:0]   low_byte_q;
  logic [30:0]  sample_total;

  result_t     awaited_words[$];
  logic [7:0]  file_bytes[$];
  int unsigned sent_bytes = 0;
  int unsigned fail_count = 0;
  int unsigned send_gap_max = 0;
  int unsigned pop_gap_max = 0;
  int unsigned pop_hold = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void clear_parser();
    parse_phase  = PH_HEADER;
    byte_pos     = '0;
    field_bits   = '0;
    riff_size_q  = '0;
    rate_q       = '0;
    brate_q      = '0;
    align_q      = '0;
    data_len_q   = '0;
    low_byte_q   = '0;
    sample_total = '0;
  endfunction

  function automatic void parse_wav_byte(in_t w);
    logic [7:0]  b;
    logic        big_end;
    logic        err_hit;
    logic [3:0]  err_code;
    logic [15:0] hi;
    result_t     r;
    b = w.byte_value;
    err_hit = 1'b0;
    err_code = ERR_RIFF;
    if (parse_phase == PH_HEADER) begin
      big_end = byte_pos < 4 || (byte_pos >= 8 && byte_pos < 16) ||
                (byte_pos >= 36 && byte_pos < 40);
      field_bits = big_end ? {field_bits[23:0], b} : {b, field_bits[31:8]};
      hi = field_bits[31:16];
      case (byte_pos)
        33'd3: if (field_bits != TagRiff) begin
          err_hit = 1'b1;
          err_code = ERR_RIFF;
        end
        33'd7: riff_size_q = field_bits;
        33'd11: if (field_bits != TagWave) begin
          err_hit = 1'b1;
          err_code = ERR_WAVE;
        end
        33'd15: if (field_bits != TagFmt) begin
          err_hit = 1'b1;
          err_code = ERR_FMT_TAG;
        end
        33'd19: if (field_bits != FmtSizePcm) begin
          err_hit = 1'b1;
          err_code = ERR_FMT_SIZE;
        end
        33'd21: if (hi != FormatPcm) begin
          err_hit = 1'b1;
          err_code = ERR_FORMAT;
        end
        33'd23: if (hi != MonoChans) begin
          err_hit = 1'b1;
          err_code = ERR_CHANNELS;
        end
        33'd27: rate_q = field_bits;
        33'd31: brate_q = field_bits;
        33'd33: align_q = hi;
        33'd35: if (hi != Bits16) begin
          err_hit = 1'b1;
          err_code = ERR_BITS;
        end
        33'd39: if (field_bits != TagData) begin
          err_hit = 1'b1;
          err_code = ERR_DATA_TAG;
        end
        33'd43: begin
          data_len_q = field_bits;
          r = '0;
          r.kind = KIND_HEADER;
          r.samp_rate = rate_q;
          r.bytes_per_sec = brate_q;
          r.frame_align = align_q;
          r.data_len = data_len_q;
          r.riff_size = riff_size_q;
          awaited_words = {awaited_words, r};
          parse_phase = PH_DATA;
        end
        default: ;
      endcase
      if (!err_hit && w.last_byte && byte_pos < HeaderLast) begin
        err_hit = 1'b1;
        err_code = ERR_TRUNCATED;
      end
      if (err_hit) begin
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = err_code;
        awaited_words = {awaited_words, r};
        parse_phase = PH_SKIP;
      end
    end else if (parse_phase == PH_DATA) begin
      if (!byte_pos[0]) begin
        low_byte_q = b;
      end else if ({1'b0, byte_pos} < {2'b00, riff_size_q} + 34'd8) begin
        r = '0;
        r.kind = KIND_SAMPLE;
        r.sample = {b, low_byte_q};
        awaited_words = {awaited_words, r};
        if (sample_total != '1) sample_total++;
      end
    end
    if (w.last_byte && parse_phase == PH_DATA) begin
      r = '0;
      r.kind = KIND_END;
      r.sample_count = sample_total;
      awaited_words = {awaited_words, r};
    end
    if (byte_pos != '1) byte_pos++;
    if (w.last_byte) clear_parser();
  endfunction

  function automatic string word_text(result_t r);
    return $sformatf({"kind=%0d sample=%0d err=%0d rate=%h brate=%h align=%h ",
                      "dsize=%h riff=%h cnt=%0d"},
                     r.kind, r.sample, r.error_code, r.samp_rate, r.bytes_per_sec,
                     r.frame_align, r.data_len, r.riff_size, r.sample_count);
  endfunction

  function automatic bit words_match(result_t a, result_t b);
    return a.kind === b.kind && a.sample === b.sample && a.error_code === b.error_code &&
           a.samp_rate === b.samp_rate && a.bytes_per_sec === b.bytes_per_sec &&
           a.frame_align === b.frame_align && a.data_len === b.data_len &&
           a.riff_size === b.riff_size && a.sample_count === b.sample_count;
  endfunction

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (awaited_words.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("Unexpected word: %s", word_text(out_word_o));
      end else begin
        want = awaited_words.pop_front();
        if (!words_match(want, out_word_o)) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Mismatch: expected %s", word_text(want));
            $display("          actual   %s", word_text(out_word_o));
          end
        end
      end
      pop_hold <= $urandom_range(0, pop_gap_max);
    end
  end

  task automatic send_word(in_t w);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    sent_bytes++;
    parse_wav_byte(w);
  endtask

  task automatic send_file();
    in_t w;
    for (int i = 0; i < file_bytes.size(); i++) begin
      w.byte_value = file_bytes[i];
      w.last_byte = (i == file_bytes.size() - 1);
      send_word(w);
    end
    file_bytes.delete();
  endtask

  task automatic put_tag(logic [31:0] t);
    file_bytes = {file_bytes, t[31:24]};
    file_bytes = {file_bytes, t[23:16]};
    file_bytes = {file_bytes, t[15:8]};
    file_bytes = {file_bytes, t[7:0]};
  endtask

  task automatic put_le16(logic [15:0] v);
    file_bytes = {file_bytes, v[7:0]};
    file_bytes = {file_bytes, v[15:8]};
  endtask

  task automatic put_le32(logic [31:0] v);
    put_le16(v[15:0]);
    put_le16(v[31:16]);
  endtask

  task automatic put_header(logic [31:0] riff, logic [31:0] rate, logic [31:0] brate,
                            logic [15:0] align, logic [31:0] dsize);
    put_tag(TagRiff);
    put_le32(riff);
    put_tag(TagWave);
    put_tag(TagFmt);
    put_le32(FmtSizePcm);
    put_le16(FormatPcm);
    put_le16(MonoChans);
    put_le32(rate);
    put_le32(brate);
    put_le16(align);
    put_le16(Bits16);
    put_tag(TagData);
    put_le32(dsize);
  endtask

  task automatic cut_file(int unsigned keep);
    while (file_bytes.size() > keep) file_bytes.delete(file_bytes.size() - 1);
  endtask

  task automatic test_header_errors();
    int unsigned bad_pos[8];
    bad_pos = '{0, 8, 12, 16, 20, 22, 34, 36};
    send_gap_max = 0;
    pop_gap_max = 7;
    for (int i = 0; i < 8; i++) begin
      put_header(32'd40, 32'd8000, 32'd16000, 16'd2, 32'd4);
      file_bytes[bad_pos[i]] ^= 8'h01;
      repeat (4) file_bytes = {file_bytes, 8'hA5};
      send_file();
    end
  endtask

  task automatic test_truncated_files();
    int unsigned cuts[5];
    cuts = '{1, 4, 20, 43, 44};
    send_gap_max = 7;
    pop_gap_max = 0;
    foreach (cuts[i]) begin
      put_header(32'd36, 32'd44100, 32'd88200, 16'd2, 32'd0);
      cut_file(cuts[i]);
      send_file();
    end
    put_tag(32'h52494658);
    send_file();
  endtask

  task automatic test_samples_and_limits();
    send_gap_max = 7;
    pop_gap_max = 7;
    put_header(32'd46, 32'd48000, 32'd96000, 16'd2, 32'd10);
    put_le16(16'h8000);
    put_le16(16'h7FFF);
    put_le16(16'h0000);
    put_le16(16'hFFFF);
    put_le16(16'h1234);
    put_le16(16'h5555);
    file_bytes = {file_bytes, 8'hAA};
    send_file();
    send_gap_max = 0;
    pop_gap_max = 0;
    put_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 32'hFFFF_FFFF);
    put_le16(16'h00FF);
    put_le16(16'hFF00);
    file_bytes = {file_bytes, 8'h7F};
    send_file();
    put_header(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
    put_le16(16'h4321);
    send_file();
  endtask

  task automatic test_random_files();
    int unsigned len;
    int unsigned pick;
    int unsigned cut;
    logic [31:0] riff;
    while (sent_bytes < 1850) begin
      pick = $urandom_range(0, 99);
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      pop_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40);
      case ($urandom_range(0, 2))
        0: riff = 36 + len;
        1: riff = 32 + len + $urandom_range(0, 8);
        default: riff = $urandom;
      endcase
      if (pick < 95) begin
        put_header(riff, $urandom, $urandom, 16'($urandom),
                   (pick < 40) ? 32'(len) : 32'($urandom));
      end
      if (pick < 80) begin
        repeat (len) file_bytes = {file_bytes, 8'($urandom)};
      end else if (pick < 90) begin
        file_bytes[$urandom_range(0, 43)] ^= 8'($urandom_range(1, 255));
        repeat ($urandom_range(0, 6)) file_bytes = {file_bytes, 8'($urandom)};
      end else if (pick < 95) begin
        cut = $urandom_range(1, 44);
        cut_file(cut);
      end else begin
        repeat ($urandom_range(1, 20)) file_bytes = {file_bytes, 8'($urandom)};
      end
      send_file();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    in_word_i = '0;
    clear_parser();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_header_errors();
    test_truncated_files();
    test_samples_and_limits();
    test_random_files();
    @(negedge clk_i);
    push <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && awaited_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
